/* sv/rdfr_pkg.sv */
// shared constants, command codes and types for the rabin root recovery block
package rdfr_pkg;

    // prime width actually used from the prime registers
    localparam int PRIME_BITS = 32;
    localparam logic [31:0] PRIME_MASK = 32'((64'd1 << PRIME_BITS) - 64'd1);

    // divider dividend width: b*b + 4*c fits in 66 bits
    localparam int DIV_W     = 66;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // signed width of the euclid coefficients
    localparam int XW = 34;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_DIV      = 4'd2;
    localparam logic [3:0] OP_MUL      = 4'd3;
    localparam logic [3:0] OP_MM       = 4'd4;
    localparam logic [3:0] OP_POW_INIT = 4'd5;
    localparam logic [3:0] OP_E_SHIFT  = 4'd6;
    localparam logic [3:0] OP_EUC_INIT = 4'd7;
    localparam logic [3:0] OP_EUC_STEP = 4'd8;
    localparam logic [3:0] OP_EUC_END  = 4'd9;
    localparam logic [3:0] OP_OUT      = 4'd10;

    // divider jobs
    localparam logic [3:0] D_BMOD = 4'd0;
    localparam logic [3:0] D_CMOD = 4'd1;
    localparam logic [3:0] D_WMOD = 4'd2;
    localparam logic [3:0] D_ACC  = 4'd3;
    localparam logic [3:0] D_XSQ  = 4'd4;
    localparam logic [3:0] D_A1   = 4'd5;
    localparam logic [3:0] D_A2   = 4'd6;
    localparam logic [3:0] D_EUC  = 4'd7;

    // multiplier jobs
    localparam logic [3:0] M_BSQ  = 4'd0;
    localparam logic [3:0] M_ACCX = 4'd1;
    localparam logic [3:0] M_XX   = 4'd2;
    localparam logic [3:0] M_TPOS = 4'd3;
    localparam logic [3:0] M_TNEG = 4'd4;
    localparam logic [3:0] M_N    = 4'd5;
    localparam logic [3:0] M_EUC  = 4'd6;

    // serial modular multiplier jobs
    localparam logic [3:0] MM_CQ  = 4'd0;
    localparam logic [3:0] MM_CP  = 4'd1;
    localparam logic [3:0] MM_1A1 = 4'd2;
    localparam logic [3:0] MM_1A2 = 4'd3;
    localparam logic [3:0] MM_2B1 = 4'd4;
    localparam logic [3:0] MM_2B2 = 4'd5;

    // register indexes of the configuration port
    localparam logic [1:0] REG_PRIME_P  = 2'd0;
    localparam logic [1:0] REG_PRIME_Q  = 2'd1;
    localparam logic [1:0] REG_OFFSET_B = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] sel;
        logic       side;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic e_zero;
        logic e_lsb;
        logic rb_zero;
        logic degen;
        logic out_free;
    } dp_stat_t;

    // (a + b) mod n for a, b below n
    function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] n);
        logic [63:0] gap;
        gap = n - b;
        if (a >= gap)
            add_mod = a - gap;
        else
            add_mod = a + b;
    endfunction

endpackage

/* sv/rabin_decrypt_four_roots.sv */
// top level of the rabin decryption block that returns all four crt roots
//
// each ciphertext word c gives four output words, the candidate plaintexts
// a1b1, a1b2, a2b1, a2b2 modulo p*q, with tuser carrying the root index and
// tlast set on the fourth. the key (primes p and q, offset b) must be written on
// the cfg port only while the block is idle, which the block itself does not
// enforce; p or q below 3 yields four zero words. one ciphertext is processed
// at a time: s_tready is high only while the sequencer is idle, and the next
// word is taken as soon as the fourth root sits in the output register. the
// time per word is set by the restoring divider that does every reduction mod
// p or q and every euclid step; per prime it grows with the bit length and
// popcount of the exponent (p+1)/4, and the two euclid runs and the six 64-bit
// shift-and-add crt multiplies add to it
module rabin_decrypt_four_roots
    import rdfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // ciphertext stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] ciphertext
    // root stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] root_value
    output logic [1:0]  m_tuser,   // [1:0] root_index
    output logic        m_tlast,   // last_root
    // key register writes: 0 prime_p, 1 prime_q, 2 offset_b
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t st;

    // sequencer: owns all control state
    rdfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: key, operands, divider, multiplier, mulmod, output word
    rdfr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // key writes are always taken
    assign cfg_ready = 1'b1;

endmodule

/* sv/rdfr_div.sv */
// restoring divider, one quotient bit per cycle
module rdfr_div
    import rdfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [31:0]      divisor,
    output logic             done,
    output logic [31:0]      quo,
    output logic [31:0]      rem
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          dsr_reg, dsr_next;
    logic [32:0]          trial;
    logic                 ge;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        ge        = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
            dvd_next = {dvd_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quo  = dvd_reg[31:0];
    assign rem  = rem_reg;

endmodule

/* sv/rdfr_mm.sv */
// shift and add modular multiplier for a 64-bit modulus, one multiplier bit per cycle
module rdfr_mm
    import rdfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x_in,
    input  logic [31:0] y_in,
    input  logic [63:0] n_in,
    output logic        done,
    output logic [63:0] res
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [63:0] n_reg, n_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        n_next    = n_reg;
        if (start)
        begin
            busy_next = 1'b1;
            acc_next  = '0;
            x_next    = x_in;
            y_next    = y_in;
            n_next    = n_in;
        end
        else if (busy_reg)
        begin
            if (y_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (y_reg[0])
                    acc_next = add_mod(acc_reg, x_reg, n_reg);
                x_next = add_mod(x_reg, x_reg, n_reg);
                y_next = y_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        n_reg   <= n_next;
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

/* sv/rdfr_dp.sv */
// datapath: key registers, operand registers, multiplier, divider, serial mulmod, output word
module rdfr_dp
    import rdfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    st,
    input  logic [63:0] s_tdata,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic [31:0] prime_p_reg, prime_q_reg, offset_b_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [1:0]  out_idx_reg;
    logic        out_last_reg;

    logic [63:0] c_reg;
    logic [31:0] bm_reg, cm_reg, x_reg, acc_reg;
    logic [30:0] e_reg;
    logic [31:0] a1_reg, a2_reg, b1_reg, b2_reg;
    logic [31:0] ra_reg, rb_reg, qt_reg, rr_reg;
    logic signed [XW-1:0] x0_reg, x1_reg;
    logic [32:0] qinv_reg, pinv_reg;
    logic [63:0] prod_reg, n_reg;
    logic [63:0] cq_reg, cp_reg, t1a1_reg, t1a2_reg, t2b1_reg, t2b2_reg;
    logic [3:0]  div_dst_reg, mm_dst_reg;

    logic [31:0] p, q, m, inv2, tpos, tneg;
    logic [32:0] spos, sneg, sneg_red;
    logic        degen;

    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dvd;
    logic [31:0]      div_dsr, div_quo, div_rem;

    logic        mm_start, mm_done;
    logic [63:0] mm_x, mm_res;
    logic [31:0] mm_y;

    logic [31:0]            mul_a32, mul_b32;
    logic signed [XW-1:0]   mul_a, mul_b;
    logic signed [2*XW-1:0] mul_full;

    logic signed [XW-1:0] euc_end;
    logic [63:0]          out_val;

    always_comb
    begin
        p     = prime_p_reg & PRIME_MASK;
        q     = prime_q_reg & PRIME_MASK;
        m     = cmd.side ? q : p;
        degen = (p < 32'd3) || (q < 32'd3);
        // inverse of 2 as extended euclid leaves it
        inv2  = m[0] ? 32'((33'(m) + 33'd1) >> 1) : 32'd1;
        // root minus offset, and negated root minus offset
        spos  = {1'b0, acc_reg} + {1'b0, m} - {1'b0, bm_reg};
        tpos  = (spos >= {1'b0, m}) ? 32'(spos - {1'b0, m}) : spos[31:0];
        sneg  = {1'b0, acc_reg} + {1'b0, bm_reg};
        sneg_red = (sneg >= {1'b0, m}) ? (sneg - {1'b0, m}) : sneg;
        tneg  = (sneg_red == '0) ? 32'd0 : 32'({1'b0, m} - sneg_red);
    end

    // divider operands
    always_comb
    begin
        div_start = cmd.op == OP_DIV;
        div_dsr   = m;
        case (cmd.sel)
            D_BMOD:  div_dvd = DIV_W'(offset_b_reg);
            D_CMOD:  div_dvd = DIV_W'(c_reg);
            D_WMOD:  div_dvd = DIV_W'(prod_reg) + DIV_W'({cm_reg, 2'b00});
            D_EUC:
            begin
                div_dvd = DIV_W'(ra_reg);
                div_dsr = rb_reg;
            end
            default: div_dvd = DIV_W'(prod_reg);
        endcase
    end

    rdfr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // mulmod operands
    always_comb
    begin
        mm_start = cmd.op == OP_MM;
        case (cmd.sel)
            MM_CQ:
            begin
                mm_x = 64'(qinv_reg);
                mm_y = q;
            end
            MM_CP:
            begin
                mm_x = 64'(pinv_reg);
                mm_y = p;
            end
            MM_1A1:
            begin
                mm_x = cq_reg;
                mm_y = a1_reg;
            end
            MM_1A2:
            begin
                mm_x = cq_reg;
                mm_y = a2_reg;
            end
            MM_2B1:
            begin
                mm_x = cp_reg;
                mm_y = b1_reg;
            end
            default:
            begin
                mm_x = cp_reg;
                mm_y = b2_reg;
            end
        endcase
    end

    rdfr_mm u_mm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .x_in  (mm_x),
        .y_in  (mm_y),
        .n_in  (n_reg),
        .done  (mm_done),
        .res   (mm_res)
    );

    // the one multiplier
    always_comb
    begin
        case (cmd.sel)
            M_BSQ:
            begin
                mul_a32 = bm_reg;
                mul_b32 = bm_reg;
            end
            M_ACCX:
            begin
                mul_a32 = acc_reg;
                mul_b32 = x_reg;
            end
            M_XX:
            begin
                mul_a32 = x_reg;
                mul_b32 = x_reg;
            end
            M_TPOS:
            begin
                mul_a32 = tpos;
                mul_b32 = inv2;
            end
            M_TNEG:
            begin
                mul_a32 = tneg;
                mul_b32 = inv2;
            end
            M_N:
            begin
                mul_a32 = p;
                mul_b32 = q;
            end
            default:
            begin
                mul_a32 = qt_reg;
                mul_b32 = '0;
            end
        endcase
        mul_a    = $signed({2'b00, mul_a32});
        mul_b    = (cmd.sel == M_EUC) ? x1_reg : $signed({2'b00, mul_b32});
        mul_full = mul_a * mul_b;
    end

    always_comb
    begin
        euc_end = x0_reg;
        if (x0_reg < 0)
            euc_end = x0_reg + $signed({2'b00, (cmd.side ? q : p)});
        case (cmd.sel[1:0])
            2'd0:    out_val = add_mod(t1a1_reg, t2b1_reg, n_reg);
            2'd1:    out_val = add_mod(t1a1_reg, t2b2_reg, n_reg);
            2'd2:    out_val = add_mod(t1a2_reg, t2b1_reg, n_reg);
            default: out_val = add_mod(t1a2_reg, t2b2_reg, n_reg);
        endcase
        if (degen)
            out_val = '0;
    end

    // key registers and output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_p_reg   <= 32'd7;
            prime_q_reg   <= 32'd11;
            offset_b_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_PRIME_P:  prime_p_reg  <= cfg_data;
                    REG_PRIME_Q:  prime_q_reg  <= cfg_data;
                    REG_OFFSET_B: offset_b_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:     c_reg <= s_tdata;
            OP_DIV:      div_dst_reg <= cmd.sel;
            OP_MM:       mm_dst_reg <= cmd.sel;
            OP_MUL:
            begin
                prod_reg <= mul_full[63:0];
                if (cmd.sel == M_N)
                    n_reg <= mul_full[63:0];
            end
            OP_POW_INIT:
            begin
                acc_reg <= 32'd1;
                e_reg   <= 31'((33'(m) + 33'd1) >> 2);
            end
            OP_E_SHIFT:  e_reg <= e_reg >> 1;
            OP_EUC_INIT:
            begin
                ra_reg <= cmd.side ? p : q;
                rb_reg <= cmd.side ? q : p;
                x0_reg <= XW'(1);
                x1_reg <= '0;
            end
            OP_EUC_STEP:
            begin
                ra_reg <= rb_reg;
                rb_reg <= rr_reg;
                x0_reg <= x1_reg;
                x1_reg <= x0_reg - $signed(prod_reg[XW-1:0]);
            end
            OP_EUC_END:
            begin
                if (cmd.side)
                    pinv_reg <= euc_end[32:0];
                else
                    qinv_reg <= euc_end[32:0];
            end
            OP_OUT:
            begin
                out_data_reg <= out_val;
                out_idx_reg  <= cmd.sel[1:0];
                out_last_reg <= cmd.sel[1:0] == 2'd3;
            end
            default: ;
        endcase

        if (div_done)
        begin
            case (div_dst_reg)
                D_BMOD:  bm_reg <= div_rem;
                D_CMOD:  cm_reg <= div_rem;
                D_WMOD:  x_reg <= div_rem;
                D_ACC:   acc_reg <= div_rem;
                D_XSQ:   x_reg <= div_rem;
                D_A1:
                begin
                    if (cmd.side)
                        b1_reg <= div_rem;
                    else
                        a1_reg <= div_rem;
                end
                D_A2:
                begin
                    if (cmd.side)
                        b2_reg <= div_rem;
                    else
                        a2_reg <= div_rem;
                end
                default:
                begin
                    qt_reg <= div_quo;
                    rr_reg <= div_rem;
                end
            endcase
        end

        if (mm_done)
        begin
            case (mm_dst_reg)
                MM_CQ:   cq_reg <= mm_res;
                MM_CP:   cp_reg <= mm_res;
                MM_1A1:  t1a1_reg <= mm_res;
                MM_1A2:  t1a2_reg <= mm_res;
                MM_2B1:  t2b1_reg <= mm_res;
                default: t2b2_reg <= mm_res;
            endcase
        end
    end

    always_comb
    begin
        st.done     = div_done | mm_done;
        st.e_zero   = e_reg == '0;
        st.e_lsb    = e_reg[0];
        st.rb_zero  = rb_reg == '0;
        st.degen    = degen;
        st.out_free = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* sv/rdfr_ctrl.sv */
// sequencer that steps the datapath through roots, euclid, crt and output
module rdfr_ctrl
    import rdfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t st,
    output dp_cmd_t  cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CHK   = 5'd1;
    localparam logic [4:0] ST_WAIT  = 5'd2;
    localparam logic [4:0] ST_BMOD  = 5'd3;
    localparam logic [4:0] ST_CMOD  = 5'd4;
    localparam logic [4:0] ST_BSQ   = 5'd5;
    localparam logic [4:0] ST_WMOD  = 5'd6;
    localparam logic [4:0] ST_PINIT = 5'd7;
    localparam logic [4:0] ST_PTEST = 5'd8;
    localparam logic [4:0] ST_PACC  = 5'd9;
    localparam logic [4:0] ST_PSQ   = 5'd10;
    localparam logic [4:0] ST_PXX   = 5'd11;
    localparam logic [4:0] ST_PSH   = 5'd12;
    localparam logic [4:0] ST_TPOS  = 5'd13;
    localparam logic [4:0] ST_A1    = 5'd14;
    localparam logic [4:0] ST_TNEG  = 5'd15;
    localparam logic [4:0] ST_A2    = 5'd16;
    localparam logic [4:0] ST_SIDE  = 5'd17;
    localparam logic [4:0] ST_N     = 5'd18;
    localparam logic [4:0] ST_E0    = 5'd19;
    localparam logic [4:0] ST_ET    = 5'd20;
    localparam logic [4:0] ST_EM    = 5'd21;
    localparam logic [4:0] ST_ES    = 5'd22;
    localparam logic [4:0] ST_M0    = 5'd23;
    localparam logic [4:0] ST_M1    = 5'd24;
    localparam logic [4:0] ST_M2    = 5'd25;
    localparam logic [4:0] ST_M3    = 5'd26;
    localparam logic [4:0] ST_M4    = 5'd27;
    localparam logic [4:0] ST_M5    = 5'd28;
    localparam logic [4:0] ST_EMIT  = 5'd29;

    logic [4:0] state_reg, state_next;
    logic [4:0] ret_reg, ret_next;
    logic       side_reg, side_next;
    logic [1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        side_next  = side_reg;
        idx_next   = idx_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = '0;
        cmd.side   = side_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                idx_next  = '0;
                side_next = 1'b0;
                state_next = st.degen ? ST_EMIT : ST_BMOD;
            end
            ST_WAIT:
            begin
                if (st.done)
                    state_next = ret_reg;
            end
            ST_BMOD:
            begin
                cmd.op = OP_DIV;
                cmd.sel = D_BMOD;
                ret_next = ST_CMOD;
                state_next = ST_WAIT;
            end
            ST_CMOD:
            begin
                cmd.op = OP_DIV;
                cmd.sel = D_CMOD;
                ret_next = ST_BSQ;
                state_next = ST_WAIT;
            end
            ST_BSQ:
            begin
                cmd.op = OP_MUL;
                cmd.sel = M_BSQ;
                state_next = ST_WMOD;
            end
            ST_WMOD:
            begin
                cmd.op = OP_DIV;
                cmd.sel = D_WMOD;
                ret_next = ST_PINIT;
                state_next = ST_WAIT;
            end
            ST_PINIT:
            begin
                cmd.op = OP_POW_INIT;
                state_next = ST_PTEST;
            end
            ST_PTEST:
            begin
                if (st.e_zero)
                    state_next = ST_TPOS;
                else if (st.e_lsb)
                begin
                    cmd.op = OP_MUL;
                    cmd.sel = M_ACCX;
                    state_next = ST_PACC;
                end
                else
                begin
                    cmd.op = OP_MUL;
                    cmd.sel = M_XX;
                    state_next = ST_PXX;
                end
            end
            ST_PACC:
            begin
                cmd.op = OP_DIV;
                cmd.sel = D_ACC;
                ret_next = ST_PSQ;
                state_next = ST_WAIT;
            end
            ST_PSQ:
            begin
                cmd.op = OP_MUL;
                cmd.sel = M_XX;
                state_next = ST_PXX;
            end
            ST_PXX:
            begin
                cmd.op = OP_DIV;
                cmd.sel = D_XSQ;
                ret_next = ST_PSH;
                state_next = ST_WAIT;
            end
            ST_PSH:
            begin
                cmd.op = OP_E_SHIFT;
                state_next = ST_PTEST;
            end
            ST_TPOS:
            begin
                cmd.op = OP_MUL;
                cmd.sel = M_TPOS;
                state_next = ST_A1;
            end
            ST_A1:
            begin
                cmd.op = OP_DIV;
                cmd.sel = D_A1;
                ret_next = ST_TNEG;
                state_next = ST_WAIT;
            end
            ST_TNEG:
            begin
                cmd.op = OP_MUL;
                cmd.sel = M_TNEG;
                state_next = ST_A2;
            end
            ST_A2:
            begin
                cmd.op = OP_DIV;
                cmd.sel = D_A2;
                ret_next = ST_SIDE;
                state_next = ST_WAIT;
            end
            ST_SIDE:
            begin
                side_next  = !side_reg;
                state_next = side_reg ? ST_N : ST_BMOD;
            end
            ST_N:
            begin
                cmd.op = OP_MUL;
                cmd.sel = M_N;
                state_next = ST_E0;
            end
            ST_E0:
            begin
                cmd.op = OP_EUC_INIT;
                state_next = ST_ET;
            end
            ST_ET:
            begin
                if (st.rb_zero)
                begin
                    cmd.op = OP_EUC_END;
                    side_next = 1'b1;
                    state_next = side_reg ? ST_M0 : ST_E0;
                end
                else
                begin
                    cmd.op = OP_DIV;
                    cmd.sel = D_EUC;
                    ret_next = ST_EM;
                    state_next = ST_WAIT;
                end
            end
            ST_EM:
            begin
                cmd.op = OP_MUL;
                cmd.sel = M_EUC;
                state_next = ST_ES;
            end
            ST_ES:
            begin
                cmd.op = OP_EUC_STEP;
                state_next = ST_ET;
            end
            ST_M0:
            begin
                cmd.op = OP_MM;
                cmd.sel = MM_CQ;
                ret_next = ST_M1;
                state_next = ST_WAIT;
            end
            ST_M1:
            begin
                cmd.op = OP_MM;
                cmd.sel = MM_CP;
                ret_next = ST_M2;
                state_next = ST_WAIT;
            end
            ST_M2:
            begin
                cmd.op = OP_MM;
                cmd.sel = MM_1A1;
                ret_next = ST_M3;
                state_next = ST_WAIT;
            end
            ST_M3:
            begin
                cmd.op = OP_MM;
                cmd.sel = MM_1A2;
                ret_next = ST_M4;
                state_next = ST_WAIT;
            end
            ST_M4:
            begin
                cmd.op = OP_MM;
                cmd.sel = MM_2B1;
                ret_next = ST_M5;
                state_next = ST_WAIT;
            end
            ST_M5:
            begin
                cmd.op = OP_MM;
                cmd.sel = MM_2B2;
                ret_next = ST_EMIT;
                state_next = ST_WAIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.op = OP_OUT;
                    cmd.sel = {2'b00, idx_reg};
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 2'd3)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            side_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            side_reg  <= side_next;
            idx_reg   <= idx_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

endmodule

/* sv/rdfr_chk.sv */
// port checker for the rabin root block and its bind
module rdfr_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // tlast only on the fourth root
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
        else $error("tlast does not match root index");

    // one ciphertext at a time
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while busy");

    // a new ciphertext only starts once the first three roots are gone
    a_in_after_roots: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid || m_tuser == 2'd3)
        else $error("word accepted with roots still pending");

    // early roots keep the block busy
    a_roots_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == 2'd0 || m_tuser == 2'd1) |=> !s_tready)
        else $error("ready before all roots issued");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

endmodule

bind rabin_decrypt_four_roots rdfr_chk u_rdfr_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
